/* design/stbs_pkg.sv */
// Shared types and constants for the sorted table with halving search.
`default_nettype none
package stbs_pkg;

	// Field widths fixed by the item layout
	localparam int CMD_W    = 2;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int POS_W    = 10;

	// Default table depth
	localparam int TABLE_DEPTH_DEF = 1024;

	// Command codes
	typedef enum logic [CMD_W-1:0] {
		CMD_APPEND = 2'd0,
		CMD_SEARCH = 2'd1,
		CMD_CLEAR  = 2'd2
	} cmd_t;

	// Result status codes
	typedef enum logic [STATUS_W-1:0] {
		STAT_OK      = 2'd0,
		STAT_FULL    = 2'd1,
		STAT_FOUND   = 2'd2,
		STAT_MISSING = 2'd3
	} status_t;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PROBE,
		ST_COMPARE,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

/* design/stbs_if.sv */
// Request and response channel interfaces for the sorted table block.
`default_nettype none
interface stbs_req_if;
	import stbs_pkg::*;

	logic                       valid;
	logic                       ready;
	logic [CMD_W-1:0]           command;
	logic signed [VALUE_W-1:0]  value;

	modport source (output valid, output command, output value, input ready);
	modport sink (input valid, input command, input value, output ready);
endinterface

interface stbs_rsp_if;
	import stbs_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [STATUS_W-1:0]  status;
	logic [POS_W-1:0]     position;

	modport source (output valid, output status, output position, input ready);
	modport sink (input valid, input status, input position, output ready);
endinterface
`default_nettype wire

/* design/stbs_mem.sv */
// Table storage: one write port, one read port with registered read data.
`default_nettype none
module stbs_mem #(
	parameter int DEPTH = stbs_pkg::TABLE_DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire                              clk,
	input  wire                              we,
	input  wire [AW-1:0]                     waddr,
	input  wire [stbs_pkg::VALUE_W-1:0]      wdata,
	input  wire                              re,
	input  wire [AW-1:0]                     raddr,
	output logic [stbs_pkg::VALUE_W-1:0]     rdata
);
	import stbs_pkg::*;

	logic [VALUE_W-1:0] entries_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			entries_q[waddr] <= wdata;
		end
	end

	// Read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= entries_q[raddr];
		end
	end
endmodule
`default_nettype wire

/* design/stbs_ctrl.sv */
// Command sequencer with the shared bound update and key compare unit.
`default_nettype none
module stbs_ctrl #(
	parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF,
	parameter int AW          = $clog2(TABLE_DEPTH)
) (
	input  wire                           clk,
	input  wire                           arst_n,
	stbs_req_if.sink                      req,
	stbs_rsp_if.source                    rsp,
	output logic                          mem_we,
	output logic [AW-1:0]                 mem_waddr,
	output logic [stbs_pkg::VALUE_W-1:0]  mem_wdata,
	output logic                          mem_re,
	output logic [AW-1:0]                 mem_raddr,
	input  wire [stbs_pkg::VALUE_W-1:0]   mem_rdata
);
	import stbs_pkg::*;

	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int BW = CW + 1;

	state_t                    state_q, state_d;
	logic [CW-1:0]             count_q;
	logic                      full;
	logic                      accept;
	logic                      handoff;
	logic signed [VALUE_W-1:0] key_q;
	logic signed [VALUE_W-1:0] probe;
	logic signed [BW-1:0]      low_q, high_q, mid_q;
	logic signed [BW-1:0]      span, mid;
	logic                      span_empty;
	logic [STATUS_W-1:0]       res_status_q;
	logic [POS_W-1:0]          res_pos_q;
	logic                      out_valid_q;
	logic [STATUS_W-1:0]       out_status_q;
	logic [POS_W-1:0]          out_pos_q;

	assign full    = (count_q == CW'(TABLE_DEPTH));
	assign accept  = req.valid && req.ready;
	assign handoff = (state_q == ST_DONE) && (!out_valid_q || rsp.ready);
	assign probe   = $signed(mem_rdata);

	// Midpoint and loop test
	assign span       = high_q - low_q;
	assign mid        = low_q + (span >>> 1);
	assign span_empty = (high_q < low_q);

	assign mem_waddr = count_q[AW-1:0];
	assign mem_wdata = req.value;
	assign mem_raddr = mid[AW-1:0];

	assign rsp.valid    = out_valid_q;
	assign rsp.status   = out_status_q;
	assign rsp.position = out_pos_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and memory strobes
	always_comb begin
		state_d   = state_q;
		req.ready = (state_q == ST_IDLE);
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					if (req.command == CMD_SEARCH) begin
						state_d = ST_PROBE;
					end else begin
						state_d = ST_DONE;
					end
					mem_we = (req.command == CMD_APPEND) && !full;
				end
			end
			ST_PROBE: begin
				if (span_empty) begin
					state_d = ST_DONE;
				end else begin
					mem_re  = 1'b1;
					state_d = ST_COMPARE;
				end
			end
			ST_COMPARE: begin
				if (probe == key_q) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_PROBE;
				end
			end
			ST_DONE: begin
				if (handoff) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			if (req.command == CMD_APPEND && !full) begin
				count_q <= count_q + CW'(1);
			end else if (req.command == CMD_CLEAR) begin
				count_q <= '0;
			end
		end
	end

	// Search bounds, key and pending result
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					key_q     <= req.value;
					low_q     <= '0;
					high_q    <= $signed({1'b0, count_q}) - BW'(1);
					res_pos_q <= '0;
					if (req.command == CMD_APPEND && full) begin
						res_status_q <= STAT_FULL;
					end else begin
						res_status_q <= STAT_OK;
					end
				end
			end
			ST_PROBE: begin
				mid_q <= mid;
				if (span_empty) begin
					res_status_q <= STAT_MISSING;
					res_pos_q    <= '0;
				end
			end
			ST_COMPARE: begin
				if (probe > key_q) begin
					high_q <= mid_q - BW'(1);
				end else if (probe < key_q) begin
					low_q <= mid_q + BW'(1);
				end else begin
					res_status_q <= STAT_FOUND;
					res_pos_q    <= POS_W'(mid_q[AW-1:0]);
				end
			end
			default: begin
			end
		endcase
	end

	// Output register: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (handoff) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register: payload
	always_ff @(posedge clk) begin
		if (handoff) begin
			out_status_q <= res_status_q;
			out_pos_q    <= res_pos_q;
		end
	end
endmodule
`default_nettype wire

/* design/sorted_table_binary_search.sv */
// Sorted table with halving search: top level.
`default_nettype none
// Keeps up to TABLE_DEPTH signed 32-bit entries, appended in order by the
// user, and answers append, search and clear commands with one response each.
// Items are taken one at a time. Append, clear and unknown commands pass from
// the idle state to the done state and then to the response register. A search
// makes P probes, at most log2(TABLE_DEPTH)+1 (11 probes at the default depth),
// and a search that misses ends in a probe state that finds the bounds crossed;
// each probe is one read of the table memory followed by one compare against
// the key. Response status: 0 appended, cleared or unknown command, 1 table
// full and value dropped, 2 found with position, 3 not found.
// The table needs no clearing after reset; the fill count alone marks the
// valid entries.
module sorted_table_binary_search #(
	parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	stbs_req_if.sink    req,
	stbs_rsp_if.source  rsp
);
	import stbs_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);

	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [VALUE_W-1:0] mem_wdata;
	logic               mem_re;
	logic [AW-1:0]      mem_raddr;
	logic [VALUE_W-1:0] mem_rdata;

	// Sequencer and compare unit
	stbs_ctrl #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.AW          (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	// Table storage
	stbs_mem #(
		.DEPTH (TABLE_DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

`ifndef SYNTHESIS
	// Table writes happen only on an append transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (req.valid && req.ready && req.command == CMD_APPEND))
		else $error("table write without append transfer");

	// A read and a write never share a cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("table read and write in the same cycle");

	// Block is busy the cycle after a request transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request taken while previous one in flight");

	// Read data is consumed while the block is still busy
	assert property (@(posedge clk) disable iff (!arst_n)
		mem_re |=> (!req.ready && !mem_re))
		else $error("probe read not followed by compare");
`endif
endmodule
`default_nettype wire
